### rtl/dkt_pkg.sv
// Shared types and character constants for the deck keyword tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package dkt_pkg;

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_BARE    = 3'd1,
		MODE_QUOTED  = 3'd2,
		MODE_SKIP    = 3'd3
	} scan_mode_t;

	typedef enum logic [1:0] {
		EV_CHAR  = 2'd0,
		EV_END   = 2'd1,
		EV_SLASH = 2'd2
	} event_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_EOI  = 1'b1
	} kind_t;

	localparam int unsigned MaxResults = 3;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		event_t     ev;
		logic [7:0] ch;
		logic       quoted;
	} result_t;

	typedef struct packed {
		scan_mode_t mode;
		logic       dash_held;
		logic       quote_is_double;
	} scan_state_t;

	typedef struct packed {
		logic [1:0]            count;
		result_t [MaxResults-1:0] res;
		scan_state_t           nxt;
	} step_out_t;

	function automatic result_t mk_result(event_t ev, logic [7:0] ch, logic quoted);
		result_t r;
		r.ev = ev;
		r.ch = ch;
		r.quoted = quoted;
		return r;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

`default_nettype wire

### rtl/dkt_if.sv
// Valid/ready channel interfaces for input bytes and output token events.
`timescale 1ns / 1ps
`default_nettype none

interface dkt_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source(output valid, output kind, output byte_value, input ready);
	modport sink(input valid, input kind, input byte_value, output ready);
endinterface

interface dkt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [7:0] char_value;
	logic       in_quotes;
	logic       last_of_run;

	modport source(output valid, output event_res, output char_value, output in_quotes,
		output last_of_run, input ready);
	modport sink(input valid, input event_res, input char_value, input in_quotes,
		input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/dkt_step.sv
// Combinational tokenizer step: next scan state and the events one input byte causes.
`timescale 1ns / 1ps
`default_nettype none

module dkt_step (
	input  wire logic                 kind,
	input  wire logic [7:0]           byte_value,
	input  wire dkt_pkg::scan_state_t cur,
	output dkt_pkg::step_out_t        step
);

	always_comb begin
		logic [1:0]           n;
		logic                 do_bare;
		dkt_pkg::scan_state_t nxt;
		dkt_pkg::scan_mode_t  mode;
		logic                 closer_hit;

		n = 2'd0;
		do_bare = 1'b0;
		step.res = '0;
		mode = (cur.mode == dkt_pkg::MODE_BARE || cur.mode == dkt_pkg::MODE_QUOTED ||
			cur.mode == dkt_pkg::MODE_SKIP) ? cur.mode : dkt_pkg::MODE_BETWEEN;
		nxt = cur;
		nxt.mode = mode;
		closer_hit = cur.quote_is_double ? (byte_value == dkt_pkg::CH_DQUOTE)
			: (byte_value == dkt_pkg::CH_SQUOTE);

		if (kind == dkt_pkg::KIND_EOI) begin
			if (cur.dash_held) begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_CHAR, dkt_pkg::CH_DASH, 1'b0);
				n = n + 2'd1;
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b0);
				n = n + 2'd1;
			end else if (mode == dkt_pkg::MODE_BARE) begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b0);
				n = n + 2'd1;
			end else if (mode == dkt_pkg::MODE_QUOTED) begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b1);
				n = n + 2'd1;
			end
			nxt.mode = dkt_pkg::MODE_BETWEEN;
			nxt.dash_held = 1'b0;
			nxt.quote_is_double = 1'b0;
		end else if (cur.dash_held) begin
			nxt.dash_held = 1'b0;
			if (byte_value == dkt_pkg::CH_DASH) begin
				if (mode == dkt_pkg::MODE_BARE) begin
					step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b0);
					n = n + 2'd1;
				end
				nxt.mode = dkt_pkg::MODE_SKIP;
			end else begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_CHAR, dkt_pkg::CH_DASH, 1'b0);
				n = n + 2'd1;
				nxt.mode = dkt_pkg::MODE_BARE;
				do_bare = 1'b1;
			end
		end else begin
			unique case (mode)
				dkt_pkg::MODE_BARE: begin
					do_bare = 1'b1;
				end
				dkt_pkg::MODE_QUOTED: begin
					if (closer_hit) begin
						step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b1);
						n = n + 2'd1;
						nxt.mode = dkt_pkg::MODE_BETWEEN;
					end else begin
						step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_CHAR, byte_value, 1'b1);
						n = n + 2'd1;
					end
				end
				dkt_pkg::MODE_SKIP: begin
					if (byte_value == dkt_pkg::CH_LF || byte_value == dkt_pkg::CH_CR) begin
						nxt.mode = dkt_pkg::MODE_BETWEEN;
					end
				end
				default: begin
					if (dkt_pkg::is_blank(byte_value)) begin
						nxt.mode = dkt_pkg::MODE_BETWEEN;
					end else if (byte_value == dkt_pkg::CH_DASH) begin
						nxt.dash_held = 1'b1;
					end else if (byte_value == dkt_pkg::CH_SLASH) begin
						step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_SLASH, 8'd0, 1'b0);
						n = n + 2'd1;
						nxt.mode = dkt_pkg::MODE_SKIP;
					end else if (byte_value == dkt_pkg::CH_SQUOTE ||
						byte_value == dkt_pkg::CH_DQUOTE) begin
						nxt.quote_is_double = (byte_value == dkt_pkg::CH_DQUOTE);
						nxt.mode = dkt_pkg::MODE_QUOTED;
					end else begin
						step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_CHAR, byte_value, 1'b0);
						n = n + 2'd1;
						nxt.mode = dkt_pkg::MODE_BARE;
					end
				end
			endcase
		end

		// A byte seen inside an open bare token, also right after a released dash.
		if (do_bare) begin
			if (dkt_pkg::is_blank(byte_value)) begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b0);
				n = n + 2'd1;
				nxt.mode = dkt_pkg::MODE_BETWEEN;
			end else if (byte_value == dkt_pkg::CH_SLASH) begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_END, 8'd0, 1'b0);
				n = n + 2'd1;
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_SLASH, 8'd0, 1'b0);
				n = n + 2'd1;
				nxt.mode = dkt_pkg::MODE_SKIP;
			end else if (byte_value == dkt_pkg::CH_DASH) begin
				nxt.dash_held = 1'b1;
			end else begin
				step.res[n] = dkt_pkg::mk_result(dkt_pkg::EV_CHAR, byte_value, 1'b0);
				n = n + 2'd1;
			end
		end

		step.count = n;
		step.nxt = nxt;
	end

endmodule

`default_nettype wire

### rtl/deck_keyword_tokenizer_core.sv
// Top level of the deck keyword tokenizer: scan state, result register and drain.
//
//  Channel  Dir  Payload                                         Transaction
//  text     in   kind, byte_value                                one input byte or end of input
//  tokens   out  event_res, char_value, in_quotes, last_of_run   one token event
//
// A byte is decoded in the cycle it is taken and its events land in the result register.
// Bytes causing zero or one event sustain one transaction per cycle on both sides while tokens is not stalled.
// A byte causing more than one event holds the result register until its last event leaves, and input waits.
// The input is taken in the same cycle the last buffered event leaves; a stall on tokens holds the input.
// Reset clears the scan state and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module deck_keyword_tokenizer_core (
	input  wire logic clk,
	input  wire logic arst_n,
	dkt_in_if.sink    text,
	dkt_out_if.source tokens
);

	dkt_pkg::scan_state_t state_q;
	dkt_pkg::step_out_t   step;

	dkt_pkg::result_t [dkt_pkg::MaxResults-1:0] res_s1;
	logic [1:0] cnt_s1;
	logic       valid_s1;
	logic [1:0] idx_q;

	logic in_fire;
	logic out_fire;
	logic at_last;

	dkt_step u_step (
		.kind       (text.kind),
		.byte_value (text.byte_value),
		.cur        (state_q),
		.step       (step)
	);

	assign at_last  = (idx_q == cnt_s1 - 2'd1);
	assign out_fire = valid_s1 && tokens.ready;
	assign text.ready = !valid_s1 || (tokens.ready && at_last);
	assign in_fire = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= dkt_pkg::MODE_BETWEEN;
			state_q.dash_held <= 1'b0;
			state_q.quote_is_double <= 1'b0;
		end else if (in_fire) begin
			state_q <= step.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= 2'd0;
		end else if (in_fire && step.count != 2'd0) begin
			valid_s1 <= 1'b1;
			idx_q <= 2'd0;
		end else if (out_fire && at_last) begin
			valid_s1 <= 1'b0;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && step.count != 2'd0) begin
			res_s1 <= step.res;
			cnt_s1 <= step.count;
		end
	end

	assign tokens.valid       = valid_s1;
	assign tokens.event_res   = res_s1[idx_q].ev;
	assign tokens.char_value  = res_s1[idx_q].ch;
	assign tokens.in_quotes   = res_s1[idx_q].quoted;
	assign tokens.last_of_run = at_last;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_s1 != 2'd0) && (idx_q < cnt_s1))
		else $error("result index beyond the buffered event count");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> text.ready)
		else $error("input blocked while the result register is empty");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && text.kind == dkt_pkg::KIND_EOI) |=>
		(state_q.mode == dkt_pkg::MODE_BETWEEN) && !state_q.dash_held)
		else $error("scan state not cleared after end of input");

	a_stall_holds_index: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !tokens.ready) |=> $stable(idx_q) && valid_s1)
		else $error("buffered event moved while output stalled");

	a_dash_not_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dash_held |-> state_q.mode != dkt_pkg::MODE_QUOTED &&
		state_q.mode != dkt_pkg::MODE_SKIP)
		else $error("dash lookahead held inside a literal or skipped line");

endmodule

`default_nettype wire
